### hdl/paq_pkg.sv
// Shared types, codes and constants for the priority admission queue.
// No dependencies; paq_ctrl, paq_dp and the top level import this package.
package paq_pkg;

  // default store depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int KIND_W    = 2;
  localparam int STATION_W = 4;
  localparam int PRIO_W    = 3;
  localparam int LENGTH_W  = 10;
  localparam int LOAD_W    = 7;
  localparam int STATUS_W  = 3;
  localparam int HCNT_W    = 4;
  localparam int TICKS_W   = 4;
  localparam int OCC_W     = 5;
  localparam int KEY_W     = PRIO_W + 1 + LENGTH_W;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_LOAD     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_MIN_PRIO = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERG_MIN_PRIO    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERG_LOAD        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERG_TICKS       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DOWN_LOAD   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HANDLERS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HANDLERS      = 4'd7;

  // register reset values
  localparam logic [LOAD_W-1:0]  RST_OVERLOAD_LOAD     = 7'd80;
  localparam logic [PRIO_W-1:0]  RST_OVERLOAD_MIN_PRIO = 3'd3;
  localparam logic [PRIO_W-1:0]  RST_EMERG_MIN_PRIO    = 3'd2;
  localparam logic [LOAD_W-1:0]  RST_EMERG_LOAD        = 7'd95;
  localparam logic [TICKS_W-1:0] RST_EMERG_TICKS       = 4'd3;
  localparam logic [LOAD_W-1:0]  RST_SCALE_DOWN_LOAD   = 7'd50;
  localparam logic [HCNT_W-1:0]  RST_MIN_HANDLERS      = 4'd5;
  localparam logic [HCNT_W-1:0]  RST_MAX_HANDLERS      = 4'd10;
  localparam logic [HCNT_W-1:0]  RST_HANDLER_COUNT     = 4'd5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] RES_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] RES_OVL_DROP = 3'd1;
  localparam logic [STATUS_W-1:0] RES_EMG_DROP = 3'd2;
  localparam logic [STATUS_W-1:0] RES_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] RES_POPPED   = 3'd4;
  localparam logic [STATUS_W-1:0] RES_EMPTY    = 3'd5;
  localparam logic [STATUS_W-1:0] RES_TICK     = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [STATION_W-1:0] station;
    logic [PRIO_W-1:0]    prio;
    logic                 critical;
    logic [LENGTH_W-1:0]  length;
    logic [LOAD_W-1:0]    load_percent;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [STATION_W-1:0] out_station;
    logic [PRIO_W-1:0]    out_prio;
    logic                 out_critical;
    logic [LENGTH_W-1:0]  out_length;
    logic [HCNT_W-1:0]    handlers;
    logic                 emergency;
    logic [OCC_W-1:0]     occupancy;
  } out_item_t;

  // stored report, station in the high bits
  typedef struct packed {
    logic [STATION_W-1:0] station;
    logic [PRIO_W-1:0]    prio;
    logic                 critical;
    logic [LENGTH_W-1:0]  length;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic                latch;
    logic                set_code;
    logic [STATUS_W-1:0] code;
    logic                advance;
    logic                push_write;
    logic                rd_en;
    logic                pop_take;
    logic                tick;
    logic                emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              drop_ovl;
    logic              drop_emg;
    logic              full;
    logic              empty;
    logic              slot_free;
    logic              scan_last;
    logic              out_free;
  } dp_sts_t;

  // ordering key, smaller is better: priority, then critical, then length
  function automatic logic [KEY_W-1:0] entry_key(entry_t e);
    entry_key = {e.prio, ~e.critical, e.length};
  endfunction

endpackage

### hdl/paq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module paq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/paq_ctrl.sv
// Sequencer of the priority admission queue: decodes each item and steps
// the datapath through push search, pop scan and result hand-off. Uses paq_pkg.
module paq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  paq_pkg::dp_sts_t sts,
  output paq_pkg::dp_cmd_t cmd
);
  import paq_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PUSH_SCAN = 3'd1;
  localparam logic [2:0] S_POP_SCAN  = 3'd2;
  localparam logic [2:0] S_POP_LAST  = 3'd3;
  localparam logic [2:0] S_POP_TAKE  = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // items are taken only between operations
  assign in_stall = (state_r != S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (sts.kind)
            KIND_PUSH: begin
              if (sts.drop_ovl) begin
                cmd.set_code = 1'b1;
                cmd.code     = RES_OVL_DROP;
                state_nxt    = S_DONE;
              end else if (sts.drop_emg) begin
                cmd.set_code = 1'b1;
                cmd.code     = RES_EMG_DROP;
                state_nxt    = S_DONE;
              end else if (sts.full) begin
                cmd.set_code = 1'b1;
                cmd.code     = RES_FULL;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_PUSH_SCAN;
              end
            end
            KIND_POP: begin
              if (sts.empty) begin
                cmd.set_code = 1'b1;
                cmd.code     = RES_EMPTY;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_POP_SCAN;
              end
            end
            KIND_TICK: begin
              cmd.tick     = 1'b1;
              cmd.set_code = 1'b1;
              cmd.code     = RES_TICK;
              state_nxt    = S_DONE;
            end
            default: begin
              // unused operation code: dropped without a result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PUSH_SCAN: begin
        // walk up from slot zero to the first free slot
        if (sts.slot_free) begin
          cmd.push_write = 1'b1;
          cmd.set_code   = 1'b1;
          cmd.code       = RES_STORED;
          state_nxt      = S_DONE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_POP_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.advance = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        // last read data is compared here
        state_nxt = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        cmd.set_code = 1'b1;
        cmd.code     = RES_POPPED;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/paq_dp.sv
// Datapath of the priority admission queue: configuration registers, slot
// store and valid bits, best-entry scan, load tracking and result register.
// Uses paq_pkg and paq_ram.
module paq_dp #(
  parameter int QUEUE_DEPTH = paq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  paq_pkg::in_item_t               in_data,
  input  logic                            cfg_we,
  input  logic [paq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [paq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  paq_pkg::dp_cmd_t                cmd,
  output paq_pkg::dp_sts_t                sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output paq_pkg::out_item_t              out_data
);
  import paq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = $bits(entry_t);

  // configuration registers
  logic [LOAD_W-1:0]  ovl_load_r;
  logic [PRIO_W-1:0]  ovl_prio_r;
  logic [PRIO_W-1:0]  emg_prio_r;
  logic [LOAD_W-1:0]  emg_load_r;
  logic [TICKS_W-1:0] emg_ticks_r;
  logic [LOAD_W-1:0]  sd_load_r;
  logic [HCNT_W-1:0]  min_hc_r;
  logic [HCNT_W-1:0]  max_hc_r;

  // queue state
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       cnt_r;
  in_item_t               item_r;
  logic [IDX_W-1:0]       scan_idx_r;
  logic                   cmp_go_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  entry_t                 best_ent_r;
  logic [STATUS_W-1:0]    res_code_r;
  entry_t                 wr_ent;
  logic [ENT_W-1:0]       rd_raw;
  entry_t                 rd_ent;
  logic                   better;

  // load tracking
  logic [LOAD_W-1:0]  stored_load_r;
  logic [TICKS_W-1:0] over_cnt_r;
  logic [TICKS_W-1:0] over_cnt_nxt;
  logic               emerg_r;
  logic               emerg_nxt;
  logic [HCNT_W-1:0]  hc_r;
  logic [HCNT_W-1:0]  hc_nxt;

  // result register
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_load_r  <= RST_OVERLOAD_LOAD;
      ovl_prio_r  <= RST_OVERLOAD_MIN_PRIO;
      emg_prio_r  <= RST_EMERG_MIN_PRIO;
      emg_load_r  <= RST_EMERG_LOAD;
      emg_ticks_r <= RST_EMERG_TICKS;
      sd_load_r   <= RST_SCALE_DOWN_LOAD;
      min_hc_r    <= RST_MIN_HANDLERS;
      max_hc_r    <= RST_MAX_HANDLERS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OVERLOAD_LOAD:     ovl_load_r  <= cfg_data[LOAD_W-1:0];
        CFG_OVERLOAD_MIN_PRIO: ovl_prio_r  <= cfg_data[PRIO_W-1:0];
        CFG_EMERG_MIN_PRIO:    emg_prio_r  <= cfg_data[PRIO_W-1:0];
        CFG_EMERG_LOAD:        emg_load_r  <= cfg_data[LOAD_W-1:0];
        CFG_EMERG_TICKS:       emg_ticks_r <= cfg_data[TICKS_W-1:0];
        CFG_SCALE_DOWN_LOAD:   sd_load_r   <= cfg_data[LOAD_W-1:0];
        CFG_MIN_HANDLERS:      min_hc_r    <= cfg_data[HCNT_W-1:0];
        CFG_MAX_HANDLERS:      max_hc_r    <= cfg_data[HCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // report store
  assign wr_ent = '{station:  item_r.station,
                    prio:     item_r.prio,
                    critical: item_r.critical,
                    length:   item_r.length};

  paq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push_write),
    .waddr (scan_idx_r),
    .wdata (wr_ent),
    .re    (cmd.rd_en),
    .raddr (scan_idx_r),
    .rdata (rd_raw)
  );

  assign rd_ent = entry_t'(rd_raw);

  // current entry beats the best so far only when strictly smaller
  assign better = cmp_go_r && cmp_vld_r &&
                  (!found_r || (entry_key(rd_ent) < entry_key(best_ent_r)));

  // valid bits, occupancy count, compare enable and found flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      cnt_r    <= '0;
      cmp_go_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      cmp_go_r <= cmd.rd_en;
      if (cmd.latch) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
      if (cmd.push_write) begin
        valid_r[scan_idx_r] <= 1'b1;
        cnt_r               <= cnt_r + CNT_W'(1);
      end else if (cmd.pop_take) begin
        valid_r[best_idx_r] <= 1'b0;
        cnt_r               <= cnt_r - CNT_W'(1);
      end
    end
  end

  // scan payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r     <= in_data;
      scan_idx_r <= '0;
    end else if (cmd.advance) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    cmp_vld_r <= valid_r[scan_idx_r];
    cmp_idx_r <= scan_idx_r;
    if (better) begin
      best_idx_r <= cmp_idx_r;
      best_ent_r <= rd_ent;
    end
    if (cmd.set_code) begin
      res_code_r <= cmd.code;
    end
  end

  // tick: handler scaling and over-limit counting
  always_comb begin
    hc_nxt = hc_r;
    if ((in_data.load_percent > ovl_load_r) && (hc_r < max_hc_r)) begin
      hc_nxt = hc_r + HCNT_W'(1);
    end else if ((in_data.load_percent < sd_load_r) && (hc_r > min_hc_r)) begin
      hc_nxt = hc_r - HCNT_W'(1);
    end
    if (in_data.load_percent > emg_load_r) begin
      over_cnt_nxt = (over_cnt_r == {TICKS_W{1'b1}}) ? over_cnt_r
                                                     : over_cnt_r + TICKS_W'(1);
      emerg_nxt    = (over_cnt_nxt > emg_ticks_r) ? 1'b1 : emerg_r;
    end else begin
      over_cnt_nxt = '0;
      emerg_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_load_r <= '0;
      over_cnt_r    <= '0;
      emerg_r       <= 1'b0;
      hc_r          <= RST_HANDLER_COUNT;
    end else if (cmd.tick) begin
      stored_load_r <= in_data.load_percent;
      over_cnt_r    <= over_cnt_nxt;
      emerg_r       <= emerg_nxt;
      hc_r          <= hc_nxt;
    end
  end

  // result register
  assign occ_wide = {{OCC_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.status <= res_code_r;
      if (res_code_r == RES_POPPED) begin
        out_data_r.out_station  <= best_ent_r.station;
        out_data_r.out_prio     <= best_ent_r.prio;
        out_data_r.out_critical <= best_ent_r.critical;
        out_data_r.out_length   <= best_ent_r.length;
      end else begin
        out_data_r.out_station  <= '0;
        out_data_r.out_prio     <= '0;
        out_data_r.out_critical <= 1'b0;
        out_data_r.out_length   <= '0;
      end
      out_data_r.handlers  <= hc_r;
      out_data_r.emergency <= emerg_r;
      out_data_r.occupancy <= occ_wide[OCC_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status toward the sequencer
  assign sts.kind      = in_data.kind;
  assign sts.drop_ovl  = (stored_load_r > ovl_load_r) && !in_data.critical &&
                         (in_data.prio > ovl_prio_r);
  assign sts.drop_emg  = emerg_r && (in_data.prio > emg_prio_r) && !in_data.critical;
  assign sts.full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty     = (cnt_r == '0);
  assign sts.slot_free = !valid_r[scan_idx_r];
  assign sts.scan_last = (scan_idx_r == IDX_W'(QUEUE_DEPTH - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

### hdl/priority_admission_queue.sv
// Bounded priority queue of station reports with load-based admission control.
// An item is taken only while the block is idle. A load tick, a dropped or
// refused push and a pop of an empty queue go straight to the result; an
// unused code is dropped with no result; a stored push walks the valid bits
// from slot zero to the lowest free slot; a pop reads every slot through
// the RAM's single read port, one slot per cycle, then takes the best. A finished
// result sits in an output register, so the next item is accepted while it
// waits; the cycle that would deliver a further result waits for it to go.
// Depends on paq_pkg, paq_ctrl, paq_dp and paq_ram.
module priority_admission_queue #(
  parameter int QUEUE_DEPTH = paq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  paq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output paq_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [paq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [paq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import paq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  paq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  paq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // report fields are zero on every result other than a pop
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != RES_POPPED)) |->
      ((out_data.out_station == '0) && (out_data.out_prio == '0) &&
       (out_data.out_critical == 1'b0) && (out_data.out_length == '0)))
    else $error("report fields set on a non-pop result");

  // an empty pop leaves nothing stored
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == RES_EMPTY)) |-> (out_data.occupancy == '0))
    else $error("empty result with nonzero occupancy");

  // a refused push only happens with every slot in use
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == RES_FULL)) |->
      (out_data.occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full result with free slots");

  // a new result is only loaded once the previous transfer is done
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule
